/* sv/dtq_pkg.sv */
`default_nettype none
package dtq_pkg;

    localparam int TIMER_ENTRIES = 16;
    localparam int READY_DEPTH   = 16;
    localparam int TASK_ID_BITS  = 8;

    localparam int TIDX_W = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
    localparam int RIDX_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int TCNT_W = $clog2(TIMER_ENTRIES + 1);
    localparam int RCNT_W = $clog2(READY_DEPTH + 1);
    localparam int MS_W   = 27;
    localparam int CLK_W  = 32;
    localparam int ID_W   = 8;

    localparam logic [MS_W-1:0] MAX_PERIOD_MS = 27'd86400000;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_REM = 2'd1;
    localparam logic [1:0] FUNC_RUN = 2'd2;

    typedef enum logic [2:0] {
        KIND_ADD_ACK  = 3'd0,
        KIND_REM_ACK  = 3'd1,
        KIND_IMM_RUN  = 3'd2,
        KIND_TMO_RUN  = 3'd3,
        KIND_RUN_DONE = 3'd4
    } kind_t;

    // best-so-far token passed along the timer cells
    typedef struct packed {
        logic              vld;
        logic [CLK_W-1:0]  deadline;
        logic [CLK_W-1:0]  stamp;
        logic [TIDX_W-1:0] idx;
    } scan_t;

    // broadcast write command to the timer cells
    typedef struct packed {
        logic                    arm;
        logic                    clear;
        logic [TIDX_W-1:0]       slot;
        logic [TASK_ID_BITS-1:0] task_id;
        logic [CLK_W-1:0]        deadline;
        logic [MS_W-1:0]         period;
        logic                    periodic;
        logic [CLK_W-1:0]        stamp;
    } tcmd_t;

    typedef struct packed {
        logic                    vld;
        logic [TASK_ID_BITS-1:0] task_id;
        logic [MS_W-1:0]         period;
        logic                    periodic;
        logic                    match;
    } tent_t;

    typedef struct packed {
        logic load;
        logic shift;
    } rctl_t;

    function automatic logic wrap_before(input logic [CLK_W-1:0] a,
                                         input logic [CLK_W-1:0] b);
        logic [CLK_W-1:0] d;
        d = a - b;
        return (d != '0) && d[CLK_W-1];
    endfunction

endpackage
`default_nettype wire

/* sv/dtq_timer_cell.sv */
`default_nettype none
module dtq_timer_cell
    import dtq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [TIDX_W-1:0]       slot_idx,
    input  wire tcmd_t                   cmd,
    input  wire logic [TASK_ID_BITS-1:0] lookup_id,
    input  wire scan_t                   scan_in,
    output      scan_t                   scan_out,
    output      tent_t                   ent
);

    logic                    vld_reg;
    logic [TASK_ID_BITS-1:0] task_reg;
    logic [CLK_W-1:0]        deadline_reg;
    logic [MS_W-1:0]         period_reg;
    logic                    periodic_reg;
    logic [CLK_W-1:0]        stamp_reg;
    scan_t                   scan_reg;
    scan_t                   scan_next;
    logic                    hit;
    logic                    take_own;

    assign hit = (cmd.slot == slot_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (hit && cmd.arm)
        begin
            vld_reg <= 1'b1;
        end
        else if (hit && cmd.clear)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit && cmd.arm)
        begin
            task_reg     <= cmd.task_id;
            deadline_reg <= cmd.deadline;
            period_reg   <= cmd.period;
            periodic_reg <= cmd.periodic;
            stamp_reg    <= cmd.stamp;
        end
    end

    // replace the token when strictly earlier, or on an equal deadline when the insert stamp is older
    always_comb
    begin
        take_own = vld_reg && (!scan_in.vld
                   || wrap_before(deadline_reg, scan_in.deadline)
                   || ((deadline_reg == scan_in.deadline)
                       && wrap_before(stamp_reg, scan_in.stamp)));
        if (take_own)
        begin
            scan_next.vld      = 1'b1;
            scan_next.deadline = deadline_reg;
            scan_next.stamp    = stamp_reg;
            scan_next.idx      = slot_idx;
        end
        else
        begin
            scan_next = scan_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out     = scan_reg;
    assign ent.vld      = vld_reg;
    assign ent.task_id  = task_reg;
    assign ent.period   = period_reg;
    assign ent.periodic = periodic_reg;
    assign ent.match    = vld_reg && (task_reg == lookup_id);

endmodule
`default_nettype wire

/* sv/dtq_ready_cell.sv */
`default_nettype none
module dtq_ready_cell
    import dtq_pkg::*;
(
    input  wire logic                    clk,
    input  wire rctl_t                   ctl,
    input  wire logic [TASK_ID_BITS-1:0] load_id,
    input  wire logic [TASK_ID_BITS-1:0] next_id,
    input  wire logic [TASK_ID_BITS-1:0] lookup_id,
    output      logic [TASK_ID_BITS-1:0] id,
    output      logic                    match
);

    logic [TASK_ID_BITS-1:0] id_reg;

    // load appends at the tail; shift pulls the neighbor toward the head
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            id_reg <= load_id;
        end
        else if (ctl.shift)
        begin
            id_reg <= next_id;
        end
    end

    assign id    = id_reg;
    assign match = (id_reg == lookup_id);

endmodule
`default_nettype wire

/* sv/deadline_timer_queue_top.sv */
`default_nettype none
// channel | signals                                        | direction
// --------+------------------------------------------------+----------
// input   | in_valid, in_stall, func, task_id, period_ms,  | in
//         | cycled, elapsed_ms                             |
// output  | out_valid, out_stall, kind, task_id_out, ok,   | out
//         | remain_ms, last                                |
//
// Add and remove pass through S_ADD or S_REM, waiting there while a held result blocks the output.
// A run emits R immediate tasks in S_IMM, then one S_SCAN and S_FIRE pass per expired
// timer (F) and a final pass; each earliest-deadline search walks the 16-cell timer chain.
// One item is in work at a time; in_stall is high until its last result is loaded.
// Reset clears the clock, the insert counter, the ready count and timer valids.
// A pending result holds in the output register while out_stall is high.
module deadline_timer_queue_top
    import dtq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_stall,
    input  wire logic [1:0]       func,
    input  wire logic [ID_W-1:0]  task_id,
    input  wire logic [MS_W-1:0]  period_ms,
    input  wire logic             cycled,
    input  wire logic [MS_W-1:0]  elapsed_ms,
    output      logic             out_valid,
    input  wire logic             out_stall,
    output      logic [2:0]       kind,
    output      logic [ID_W-1:0]  task_id_out,
    output      logic             ok,
    output      logic [MS_W-1:0]  remain_ms,
    output      logic             last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REM,
        S_IMM,
        S_SCAN,
        S_FIRE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CLK_W-1:0]        now_reg, now_next;
    logic [CLK_W-1:0]        ins_reg, ins_next;
    logic [RCNT_W-1:0]       rcount_reg, rcount_next;
    logic [TCNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [TASK_ID_BITS-1:0] id_reg, id_next;
    logic [MS_W-1:0]         period_reg, period_next;
    logic                    cycled_reg, cycled_next;

    logic                    out_valid_reg, out_valid_next;
    kind_t                   kind_reg, kind_next;
    logic [ID_W-1:0]         tid_reg, tid_next;
    logic                    ok_reg, ok_next;
    logic [MS_W-1:0]         remain_reg, remain_next;
    logic                    last_reg, last_next;

    tcmd_t                   tcmd;
    scan_t                   scan_chain [TIMER_ENTRIES+1];
    tent_t                   tent [TIMER_ENTRIES];
    logic [TIMER_ENTRIES-1:0] tmatch;
    logic [TIMER_ENTRIES-1:0] tfree;

    rctl_t                   rctl [READY_DEPTH];
    logic [TASK_ID_BITS-1:0] rid [READY_DEPTH+1];
    logic [READY_DEPTH-1:0]  rhit;

    scan_t                   best;
    tent_t                   best_ent;
    logic [CLK_W-1:0]        best_d;
    logic                    out_free;
    logic [TIDX_W-1:0]       hit_slot;
    logic [TIDX_W-1:0]       free_slot;
    logic [RIDX_W-1:0]       rpos;

    function automatic logic [TIDX_W-1:0] first_t(input logic [TIMER_ENTRIES-1:0] v);
        logic [TIDX_W-1:0] r;
        r = '0;
        for (int i = TIMER_ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = TIDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [RIDX_W-1:0] first_r(input logic [READY_DEPTH-1:0] v);
        logic [RIDX_W-1:0] r;
        r = '0;
        for (int i = READY_DEPTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = RIDX_W'(i);
            end
        end
        return r;
    endfunction

    assign scan_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TIMER_ENTRIES; gi++)
        begin : g_timer
            dtq_timer_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .slot_idx  (TIDX_W'(gi)),
                .cmd       (tcmd),
                .lookup_id (id_reg),
                .scan_in   (scan_chain[gi]),
                .scan_out  (scan_chain[gi+1]),
                .ent       (tent[gi])
            );
            assign tmatch[gi] = tent[gi].match;
            assign tfree[gi]  = !tent[gi].vld;
        end

        assign rid[READY_DEPTH] = '0;
        for (gi = 0; gi < READY_DEPTH; gi++)
        begin : g_ready
            logic m;
            dtq_ready_cell u_cell (
                .clk       (clk),
                .ctl       (rctl[gi]),
                .load_id   (id_reg),
                .next_id   (rid[gi+1]),
                .lookup_id (id_reg),
                .id        (rid[gi]),
                .match     (m)
            );
            assign rhit[gi] = m && (RCNT_W'(gi) < rcount_reg);
        end
    endgenerate

    assign best      = scan_chain[TIMER_ENTRIES];
    assign best_ent  = tent[best.idx];
    assign best_d    = best.deadline - now_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign hit_slot  = first_t(tmatch);
    assign free_slot = first_t(tfree);
    assign rpos      = first_r(rhit);

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        ins_next       = ins_reg;
        rcount_next    = rcount_reg;
        scan_cnt_next  = scan_cnt_reg;
        id_next        = id_reg;
        period_next    = period_reg;
        cycled_next    = cycled_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        tid_next       = tid_reg;
        ok_next        = ok_reg;
        remain_next    = remain_reg;
        last_next      = last_reg;
        tcmd           = '0;
        for (int k = 0; k < READY_DEPTH; k++)
        begin
            rctl[k] = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next     = task_id[TASK_ID_BITS-1:0];
                    period_next = period_ms;
                    cycled_next = cycled;
                    case (func)
                        FUNC_ADD: state_next = S_ADD;
                        FUNC_REM: state_next = S_REM;
                        FUNC_RUN:
                        begin
                            now_next   = now_reg + CLK_W'(elapsed_ms);
                            state_next = S_IMM;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end

            S_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ADD_ACK;
                    tid_next       = ID_W'(id_reg);
                    remain_next    = '0;
                    last_next      = 1'b1;
                    ok_next        = 1'b0;
                    state_next     = S_IDLE;
                    if (period_reg == '0)
                    begin
                        if (!(|rhit) && (rcount_reg < RCNT_W'(READY_DEPTH)))
                        begin
                            ok_next     = 1'b1;
                            rcount_next = rcount_reg + 1'b1;
                            for (int k = 0; k < READY_DEPTH; k++)
                            begin
                                if (RCNT_W'(k) == rcount_reg)
                                begin
                                    rctl[k].load = 1'b1;
                                end
                            end
                        end
                    end
                    else if ((period_reg < MAX_PERIOD_MS) && !(|tmatch) && (|tfree))
                    begin
                        ok_next       = 1'b1;
                        tcmd.arm      = 1'b1;
                        tcmd.slot     = free_slot;
                        tcmd.task_id  = id_reg;
                        tcmd.deadline = now_reg + CLK_W'(period_reg);
                        tcmd.period   = period_reg;
                        tcmd.periodic = cycled_reg;
                        tcmd.stamp    = ins_reg;
                        ins_next      = ins_reg + 1'b1;
                    end
                end
            end

            S_REM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_REM_ACK;
                    tid_next       = ID_W'(id_reg);
                    remain_next    = '0;
                    last_next      = 1'b1;
                    ok_next        = 1'b0;
                    state_next     = S_IDLE;
                    if (|tmatch)
                    begin
                        ok_next    = 1'b1;
                        tcmd.clear = 1'b1;
                        tcmd.slot  = hit_slot;
                    end
                    else if (|rhit)
                    begin
                        // close the gap: cells from the hit onward pull their neighbor
                        ok_next     = 1'b1;
                        rcount_next = rcount_reg - 1'b1;
                        for (int k = 0; k < READY_DEPTH; k++)
                        begin
                            if (RIDX_W'(k) >= rpos)
                            begin
                                rctl[k].shift = 1'b1;
                            end
                        end
                    end
                end
            end

            S_IMM:
            begin
                if (rcount_reg == '0)
                begin
                    scan_cnt_next = '0;
                    state_next    = S_SCAN;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_IMM_RUN;
                    tid_next       = ID_W'(rid[0]);
                    ok_next        = 1'b0;
                    remain_next    = '0;
                    last_next      = 1'b0;
                    rcount_next    = rcount_reg - 1'b1;
                    for (int k = 0; k < READY_DEPTH; k++)
                    begin
                        rctl[k].shift = 1'b1;
                    end
                end
            end

            S_SCAN:
            begin
                // wait for the token to cross every cell
                if (scan_cnt_reg == TCNT_W'(TIMER_ENTRIES))
                begin
                    state_next = S_FIRE;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end

            S_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = 1'b0;
                    remain_next    = '0;
                    if (!best.vld || ((best_d != '0) && !best_d[CLK_W-1]))
                    begin
                        kind_next  = KIND_RUN_DONE;
                        tid_next   = '0;
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                        if (best.vld)
                        begin
                            remain_next = best_d[MS_W-1:0];
                        end
                    end
                    else
                    begin
                        kind_next     = KIND_TMO_RUN;
                        tid_next      = ID_W'(best_ent.task_id);
                        last_next     = 1'b0;
                        scan_cnt_next = '0;
                        state_next    = S_SCAN;
                        tcmd.slot     = best.idx;
                        if (best_ent.periodic)
                        begin
                            tcmd.arm      = 1'b1;
                            tcmd.task_id  = best_ent.task_id;
                            tcmd.deadline = now_reg + CLK_W'(best_ent.period);
                            tcmd.period   = best_ent.period;
                            tcmd.periodic = 1'b1;
                            tcmd.stamp    = ins_reg;
                            ins_next      = ins_reg + 1'b1;
                        end
                        else
                        begin
                            tcmd.clear = 1'b1;
                        end
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            ins_reg       <= '0;
            rcount_reg    <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            ins_reg       <= ins_next;
            rcount_reg    <= rcount_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        period_reg <= period_next;
        cycled_reg <= cycled_next;
        kind_reg   <= kind_next;
        tid_reg    <= tid_next;
        ok_reg     <= ok_next;
        remain_reg <= remain_next;
        last_reg   <= last_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign task_id_out = tid_reg;
    assign ok          = ok_reg;
    assign remain_ms   = remain_reg;
    assign last        = last_reg;

    a_rcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg <= RCNT_W'(READY_DEPTH))
        else $error("ready count beyond depth");

    a_timer_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tmatch))
        else $error("task id owns more than one timer");

    a_ready_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD || state_reg == S_REM) |-> $onehot0(rhit))
        else $error("task id queued twice");

    a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIRE && best.vld) |-> best_ent.vld)
        else $error("search picked an empty timer slot");

endmodule
`default_nettype wire

/* dv/dtq_checker.sv */
`timescale 1ns / 1ps
module dtq_checker
    import dtq_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_stall,
    input  wire logic [1:0]      func,
    input  wire logic [ID_W-1:0] task_id,
    input  wire logic [MS_W-1:0] period_ms,
    input  wire logic            cycled,
    input  wire logic [MS_W-1:0] elapsed_ms,
    input  wire logic            out_valid,
    input  wire logic            out_stall,
    input  wire logic [2:0]      kind,
    input  wire logic [ID_W-1:0] task_id_out,
    input  wire logic            ok,
    input  wire logic [MS_W-1:0] remain_ms,
    input  wire logic            last,
    output int                   fail_count,
    output int                   pending_count
);

    typedef struct {
        kind_t           kind;
        logic [ID_W-1:0] task_id;
        logic            ok;
        logic [MS_W-1:0] remain;
        logic            last;
    } sched_event_t;

    sched_event_t sched_q[$];

    logic [CLK_W-1:0] clock_ms;
    logic             tmr_on[TIMER_ENTRIES];
    logic [ID_W-1:0]  tmr_id[TIMER_ENTRIES];
    logic [CLK_W-1:0] tmr_due[TIMER_ENTRIES];
    logic [MS_W-1:0]  tmr_period[TIMER_ENTRIES];
    logic             tmr_repeat[TIMER_ENTRIES];
    logic [CLK_W-1:0] tmr_order[TIMER_ENTRIES];
    logic [CLK_W-1:0] order_ctr;
    logic [ID_W-1:0]  ready_ids[READY_DEPTH];
    int               ready_n;

    function automatic bit earlier(input logic [CLK_W-1:0] a, input logic [CLK_W-1:0] b);
        logic [CLK_W-1:0] d;
        d = a - b;
        return (d != '0) && d[CLK_W-1];
    endfunction

    function automatic void post(input kind_t k, input logic [ID_W-1:0] id,
                                 input logic good, input logic [MS_W-1:0] rem);
        sched_event_t e;
        e.kind = k;
        e.task_id = id;
        e.ok = good;
        e.remain = rem;
        e.last = 1'b0;
        sched_q.insert(sched_q.size(), e);
    endfunction

    function automatic int timer_of(input logic [ID_W-1:0] id);
        for (int i = 0; i < TIMER_ENTRIES; i++)
            if (tmr_on[i] && tmr_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int ready_of(input logic [ID_W-1:0] id);
        for (int i = 0; i < ready_n; i++)
            if (ready_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void arm(input int s, input logic [ID_W-1:0] id,
                                input logic [MS_W-1:0] p, input logic rep);
        tmr_on[s] = 1'b1;
        tmr_id[s] = id;
        tmr_due[s] = clock_ms + CLK_W'(p);
        tmr_period[s] = p;
        tmr_repeat[s] = rep;
        tmr_order[s] = order_ctr;
        order_ctr++;
    endfunction

    function automatic logic do_add(input logic [ID_W-1:0] id, input logic [MS_W-1:0] p,
                                    input logic rep);
        if (p == '0)
        begin
            if (ready_of(id) >= 0 || ready_n >= READY_DEPTH)
                return 1'b0;
            ready_ids[ready_n] = id;
            ready_n++;
            return 1'b1;
        end
        if (p >= MAX_PERIOD_MS || timer_of(id) >= 0)
            return 1'b0;
        for (int i = 0; i < TIMER_ENTRIES; i++)
        begin
            if (!tmr_on[i])
            begin
                arm(i, id, p, rep);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic do_remove(input logic [ID_W-1:0] id);
        int t;
        t = timer_of(id);
        if (t >= 0)
        begin
            tmr_on[t] = 1'b0;
            return 1'b1;
        end
        t = ready_of(id);
        if (t < 0)
            return 1'b0;
        for (int k = t; k + 1 < ready_n; k++)
            ready_ids[k] = ready_ids[k + 1];
        ready_n--;
        return 1'b1;
    endfunction

    function automatic int soonest();
        int best;
        best = -1;
        for (int i = 0; i < TIMER_ENTRIES; i++)
        begin
            if (!tmr_on[i])
                continue;
            if (best < 0 || earlier(tmr_due[i], tmr_due[best]) ||
                (tmr_due[i] == tmr_due[best] && earlier(tmr_order[i], tmr_order[best])))
                best = i;
        end
        return best;
    endfunction

    function automatic void predict_schedule(input logic [1:0] f, input logic [ID_W-1:0] id,
                                             input logic [MS_W-1:0] p, input logic rep,
                                             input logic [MS_W-1:0] el);
        logic [CLK_W-1:0] d;
        logic [CLK_W-1:0] rem;
        int t;
        if (f == FUNC_ADD)
            post(KIND_ADD_ACK, id, do_add(id, p, rep), '0);
        else if (f == FUNC_REM)
            post(KIND_REM_ACK, id, do_remove(id), '0);
        else if (f == FUNC_RUN)
        begin
            rem = '0;
            clock_ms = clock_ms + CLK_W'(el);
            for (int k = 0; k < ready_n; k++)
                post(KIND_IMM_RUN, ready_ids[k], 1'b0, '0);
            ready_n = 0;
            forever
            begin
                t = soonest();
                if (t < 0)
                    break;
                d = tmr_due[t] - clock_ms;
                if (d != '0 && !d[CLK_W-1])
                begin
                    rem = d;
                    break;
                end
                post(KIND_TMO_RUN, tmr_id[t], 1'b0, '0);
                tmr_on[t] = 1'b0;
                if (tmr_repeat[t])
                    arm(t, tmr_id[t], tmr_period[t], 1'b1);
            end
            post(KIND_RUN_DONE, '0, 1'b0, rem[MS_W-1:0]);
        end
        else
            return;
        sched_q[sched_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_event_t e;
        if (!rst_n)
        begin
            clock_ms = '0;
            order_ctr = '0;
            ready_n = 0;
            fail_count = 0;
            for (int i = 0; i < TIMER_ENTRIES; i++)
                tmr_on[i] = 1'b0;
            sched_q.delete();
        end
        else
        begin
            // check outputs before predicting a new transfer at the same edge
            if (out_valid && !out_stall)
            begin
                if (sched_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result kind=%0d id=%0d ok=%0b rem=%0d last=%0b",
                                 kind, task_id_out, ok, remain_ms, last);
                end
                else
                begin
                    e = sched_q.pop_front();
                    if (kind != e.kind || task_id_out != e.task_id || ok != e.ok ||
                        remain_ms != e.remain || last != e.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch exp kind=%0d id=%0d ok=%0b rem=%0d last=%0b,",
                                      " got kind=%0d id=%0d ok=%0b rem=%0d last=%0b"},
                                     e.kind, e.task_id, e.ok, e.remain, e.last,
                                     kind, task_id_out, ok, remain_ms, last);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_schedule(func, task_id, period_ms, cycled, elapsed_ms);
        end
        pending_count = sched_q.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import dtq_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [1:0]      func;
    logic [ID_W-1:0] task_id;
    logic [MS_W-1:0] period_ms;
    logic            cycled;
    logic [MS_W-1:0] elapsed_ms;
    logic            out_valid;
    logic            out_stall;
    logic [2:0]      kind;
    logic [ID_W-1:0] task_id_out;
    logic            ok;
    logic [MS_W-1:0] remain_ms;
    logic            last;
    int              fail_count;
    int              pending_count;

    bit hold_req;
    int burst_left;
    int gap_len;

    deadline_timer_queue_top i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .task_id(task_id), .period_ms(period_ms), .cycled(cycled),
        .elapsed_ms(elapsed_ms), .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .task_id_out(task_id_out), .ok(ok), .remain_ms(remain_ms),
        .last(last)
    );

    dtq_checker i_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .task_id(task_id), .period_ms(period_ms), .cycled(cycled),
        .elapsed_ms(elapsed_ms), .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .task_id_out(task_id_out), .ok(ok), .remain_ms(remain_ms),
        .last(last), .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #20ms;
        $display("FAIL deadline_timer_queue_top");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        bit held;
        mode = 0;
        mode_left = 0;
        held = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                held = 1;
                out_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 1);
                    2: out_stall <= (mode_left % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send(input logic [1:0] f, input logic [ID_W-1:0] id,
                        input logic [MS_W-1:0] p, input logic c, input logic [MS_W-1:0] el);
        @(negedge clk);
        func <= f;
        task_id <= id;
        period_ms <= p;
        cycled <= c;
        elapsed_ms <= el;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap_len - 1) @(negedge clk);
            end
        end
        else
            burst_left--;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        return ($urandom_range(0, 4) != 0) ? ID_W'($urandom_range(0, 19)) : ID_W'($urandom);
    endfunction

    function automatic logic [MS_W-1:0] pick_period();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: return '0;
            6, 7, 8, 9, 10, 11, 12, 13: return MS_W'($urandom_range(1, 2000));
            14, 15, 16, 17: return MS_W'($urandom_range(1, 86399999));
            18: return MS_W'($urandom_range(86400000, (1 << MS_W) - 1));
            default: return MS_W'($urandom);
        endcase
    endfunction

    function automatic logic [MS_W-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2, 3, 4, 5: return MS_W'($urandom_range(0, 3000));
            6, 7, 8: return MS_W'($urandom);
            default: return 27'd86400000;
        endcase
    endfunction

    initial
    begin
        int sel;
        logic [1:0] f;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_ADD;
        task_id = '0;
        period_ms = '0;
        cycled = 1'b0;
        elapsed_ms = '0;
        hold_req = 0;
        burst_left = 0;
        gap_len = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(FUNC_RUN, 8'd0, '0, 1'b0, '0);
        send(FUNC_ADD, 8'd5, '0, 1'b0, '0);
        send(FUNC_ADD, 8'd5, '0, 1'b1, '0);
        send(FUNC_ADD, 8'd7, 27'd1, 1'b1, '0);
        send(FUNC_ADD, 8'd7, 27'd50, 1'b0, '0);
        send(FUNC_ADD, 8'd9, 27'd86400000, 1'b0, '0);
        send(FUNC_ADD, 8'd9, '1, 1'b1, '1);
        send(FUNC_ADD, 8'd9, 27'd86399999, 1'b0, '0);
        send(FUNC_REM, 8'd200, '0, 1'b0, '0);
        send(FUNC_ADD, 8'd6, '0, 1'b0, '0);
        send(FUNC_REM, 8'd6, '0, 1'b0, '0);
        send(FUNC_UNUSED, 8'hFF, '1, 1'b1, '1);
        send(FUNC_RUN, 8'd0, '0, 1'b0, '0);
        send(FUNC_RUN, 8'd0, '0, 1'b0, 27'd1);
        send(FUNC_REM, 8'd7, '0, 1'b0, '0);
        send(FUNC_ADD, 8'd255, 27'd10, 1'b0, '0);
        send(FUNC_ADD, 8'd0, 27'd10, 1'b0, '0);
        send(FUNC_RUN, 8'd0, '0, 1'b0, 27'd86400000);
        send(FUNC_RUN, 8'hAA, '1, 1'b1, '1);
        // fill both tables past capacity, then expire everything in one run
        for (int i = 0; i < 17; i++)
            send(FUNC_ADD, ID_W'(100 + i), '0, 1'b0, '0);
        for (int i = 0; i < 17; i++)
            send(FUNC_ADD, ID_W'(100 + i), 27'd5, 1'b1, '0);
        send(FUNC_RUN, 8'd0, '0, 1'b0, 27'd5);
        for (int i = 0; i < 16; i++)
            send(FUNC_REM, ID_W'(100 + i), '0, 1'b0, '0);

        for (int n = 0; n < 310; n++)
        begin
            if (n == 150)
                hold_req = 1;
            sel = $urandom_range(0, 19);
            if (sel < 9)
                f = FUNC_ADD;
            else if (sel < 13)
                f = FUNC_REM;
            else if (sel < 19)
                f = FUNC_RUN;
            else
                f = FUNC_UNUSED;
            send(f, pick_id(), pick_period(), 1'($urandom), pick_elapsed());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS deadline_timer_queue_top");
        else
            $display("FAIL deadline_timer_queue_top");
        $finish;
    end

endmodule

/* deadline_timer_queue_top.f */
sv/dtq_pkg.sv
sv/dtq_timer_cell.sv
sv/dtq_ready_cell.sv
sv/deadline_timer_queue_top.sv
dv/dtq_checker.sv
dv/testbench.sv
